@@ rtl/pcme_pkg.sv @@
// Shared constants, types and codes for the prefix cache match engine.
package pcme_pkg;

  localparam int DEPTH            = 1024;
  localparam int VALUE_BITS       = 64;
  localparam int MAX_MEDIA_TOKENS = 4096;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = 11;
  localparam int TOK_W   = 23;
  localparam int ELEN_W  = 13;
  localparam int VAL_IN_W = 64;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 1;

  localparam logic [TOK_W-1:0] TOK_SAT = {TOK_W{1'b1}};

  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_MATCH    = 2'd1;
  localparam logic [1:0] OP_TRUNCATE = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
    logic [ELEN_W-1:0]     tokens;
    logic [TOK_W-1:0]      prefix;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } pcme_cmd_t;

endpackage

@@ rtl/pcme_ctrl.sv @@
// Controller: load/execute sequencing and output valid handling.
module pcme_ctrl
  import pcme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output pcme_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = slot_free;
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.exec) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/pcme_datapath.sv @@
// Datapath: entry store, list and query state, compare and result register.
module pcme_datapath
  import pcme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcme_cmd_t             cmd,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // element_value, media_token_length, keep_count
  input  logic [IN_USER_W-1:0]  in_tuser,   // opcode, is_media, query_first
  input  logic                  in_tlast,   // query_last
  output logic [OUT_DATA_W-1:0] out_tdata,  // hit_count, hit_tokens,
                                            // stored_elements, stored_tokens, pad
  output logic [OUT_USER_W-1:0] out_tuser,  // dropped_full
  output logic                  out_tlast   // match_done
);

  function automatic logic [TOK_W-1:0] sat_add(input logic [TOK_W-1:0] a,
                                               input logic [ELEN_W-1:0] b);
    logic [TOK_W:0] s;
    s = {1'b0, a} + {{(TOK_W+1-ELEN_W){1'b0}}, b};
    sat_add = s[TOK_W] ? TOK_SAT : s[TOK_W-1:0];
  endfunction

  entry_t mem [DEPTH];
  entry_t rd_data_r;
  entry_t wr_word;
  logic   wr_en;

  // input field unpacking
  logic [1:0]            in_op;
  logic                  in_kind;
  logic                  in_first;
  logic [VAL_IN_W-1:0]   in_val;
  logic [ELEN_W-1:0]     in_mlen;
  logic [CNT_W-1:0]      in_keep;
  logic [ELEN_W-1:0]     in_len;
  logic [ADDR_W-1:0]     rd_addr;

  assign in_op    = in_tuser[1:0];
  assign in_kind  = in_tuser[2];
  assign in_first = in_tuser[3];
  assign in_val   = in_tdata[VAL_IN_W-1:0];
  assign in_mlen  = in_tdata[VAL_IN_W+ELEN_W-1:VAL_IN_W];
  assign in_keep  = in_tdata[VAL_IN_W+ELEN_W+CNT_W-1:VAL_IN_W+ELEN_W];

  always_comb begin
    if (!in_kind) in_len = ELEN_W'(1);
    else if (in_mlen > ELEN_W'(MAX_MEDIA_TOKENS)) in_len = ELEN_W'(MAX_MEDIA_TOKENS);
    else in_len = in_mlen;
  end

  // held item
  logic [1:0]            op_r;
  logic                  kind_r;
  logic                  first_r;
  logic                  last_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [ELEN_W-1:0]     len_r;
  logic [CNT_W-1:0]      keep_r;

  // list and query state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOK_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] qidx_r, qidx_nxt;
  logic             alive_r, alive_nxt;
  logic [CNT_W-1:0] qel_r, qel_nxt;
  logic [TOK_W-1:0] qtok_r, qtok_nxt;

  logic [CNT_W-1:0] qi, qe;
  logic [TOK_W-1:0] qt;
  logic             alv, hit;
  logic [CNT_W-1:0] keep_m1;

  assign qi = first_r ? '0 : qidx_r;
  assign qe = first_r ? '0 : qel_r;
  assign qt = first_r ? '0 : qtok_r;
  assign alv = first_r | alive_r;

  // read address at load time, from the arriving item and current state
  always_comb begin
    keep_m1 = in_keep - CNT_W'(1);
    if (in_op == OP_TRUNCATE) rd_addr = keep_m1[ADDR_W-1:0];
    else if (in_first)        rd_addr = '0;
    else                      rd_addr = qidx_r[ADDR_W-1:0];
  end

  assign hit = alv && (qi < count_r) && (rd_data_r.kind == kind_r) &&
               (rd_data_r.value == val_r) &&
               (!kind_r || (rd_data_r.tokens == len_r));

  logic [CNT_W-1:0] m_el;
  logic [TOK_W-1:0] m_tok;
  logic             done, dropped;

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    qidx_nxt  = qidx_r;
    alive_nxt = alive_r;
    qel_nxt   = qel_r;
    qtok_nxt  = qtok_r;
    wr_en     = 1'b0;
    m_el      = '0;
    m_tok     = '0;
    done      = 1'b0;
    dropped   = 1'b0;
    wr_word.kind   = kind_r;
    wr_word.value  = val_r;
    wr_word.tokens = len_r;
    wr_word.prefix = sat_add(total_r, len_r);
    case (op_r)
      OP_APPEND: begin
        if (count_r < CNT_W'(DEPTH)) begin
          wr_en     = 1'b1;
          total_nxt = wr_word.prefix;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          dropped = 1'b1;
        end
      end
      OP_MATCH: begin
        qel_nxt   = qe;
        qtok_nxt  = qt;
        alive_nxt = alv;
        if (alv) begin
          if (hit) begin
            qel_nxt  = qe + CNT_W'(1);
            qtok_nxt = sat_add(qt, rd_data_r.tokens);
          end else begin
            alive_nxt = 1'b0;
          end
        end
        qidx_nxt = (qi < CNT_W'(DEPTH)) ? qi + CNT_W'(1) : qi;
        m_el  = qel_nxt;
        m_tok = qtok_nxt;
        done  = last_r;
      end
      OP_TRUNCATE: begin
        if (keep_r < count_r) begin
          total_nxt = (keep_r == '0) ? '0 : rd_data_r.prefix;
          count_nxt = keep_r;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
        total_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) rd_data_r <= mem[rd_addr];
    if (cmd.exec && wr_en) mem[count_r[ADDR_W-1:0]] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      kind_r  <= in_kind;
      first_r <= in_first;
      last_r  <= in_tlast;
      val_r   <= in_val[VALUE_BITS-1:0];
      len_r   <= in_len;
      keep_r  <= in_keep;
    end
    if (cmd.exec) begin
      out_tdata <= {(OUT_DATA_W-2*CNT_W-2*TOK_W)'(0), total_nxt, count_nxt, m_tok, m_el};
      out_tuser <= dropped;
      out_tlast <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      qidx_r  <= '0;
      alive_r <= 1'b1;
      qel_r   <= '0;
      qtok_r  <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      total_r <= total_nxt;
      qidx_r  <= qidx_nxt;
      alive_r <= alive_nxt;
      qel_r   <= qel_nxt;
      qtok_r  <= qtok_nxt;
    end
  end

endmodule

@@ rtl/prefix_cache_match_engine_top.sv @@
// Top level of the prefix cache match engine.
//
// Input channel in_*: one item per command. in_tuser selects the operation
// (append, match, truncate, clear), gives the element kind and the query
// start mark; in_tlast marks the last element of a match query. tdata holds
// the element value, media token length and truncate keep count.
// Output channel out_*: exactly one result item per input item, in order,
// carrying the running match counts and the stored element and token counts;
// out_tlast flags the end of a query, out_tuser a dropped append.
// Each item first reads the entry store (one synchronous read port), then
// compares or updates and loads the output register. A new item is accepted
// only after the previous one has loaded its result into the output register;
// out_tvalid rises once that result is registered.
// The result sits in an output register, so the next item is accepted while
// a result waits; if the receiver still stalls when the second item is
// ready, the block holds it and accepts nothing more until out_tready.
// Reset empties the list and restarts query state; no clearing pass runs.
module prefix_cache_match_engine_top
  import pcme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // element_value, media_token_length, keep_count
  input  logic [IN_USER_W-1:0]  in_tuser,   // opcode, is_media, query_first
  input  logic                  in_tlast,   // query_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // hit_count, hit_tokens,
                                            // stored_elements, stored_tokens, pad
  output logic [OUT_USER_W-1:0] out_tuser,  // dropped_full
  output logic                  out_tlast   // match_done
);

  pcme_cmd_t cmd;

  pcme_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pcme_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for prefix_cache_match_engine_top: directed, full-store and random tests.
module testbench;
  import pcme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned TOTAL_ITEMS    = 1650;
  localparam int unsigned TOK_MAX        = 8388607;

  typedef struct packed {
    logic [CNT_W-1:0] m_el;
    logic [TOK_W-1:0] m_tok;
    logic             done;
    logic [CNT_W-1:0] st_el;
    logic [TOK_W-1:0] st_tok;
    logic             dropped;
  } cache_counts_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  // shadow of the element store and query state
  logic              sh_kind   [DEPTH];
  logic [63:0]       sh_value  [DEPTH];
  logic [ELEN_W-1:0] sh_len    [DEPTH];
  logic [TOK_W-1:0]  sh_prefix [DEPTH];
  int unsigned       n_stored = 0;
  int unsigned       tok_total = 0;
  int unsigned       q_idx = 0;
  bit                q_alive = 1'b1;
  int unsigned       q_elems = 0;
  int unsigned       q_toks = 0;

  cache_counts_t match_counts_due[$];
  int unsigned   mismatches = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  bit            calm = 1'b0;

  prefix_cache_match_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    cache_counts_t seen;
    cache_counts_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.m_el    = out_tdata[10:0];
      seen.m_tok   = out_tdata[33:11];
      seen.st_el   = out_tdata[44:34];
      seen.st_tok  = out_tdata[67:45];
      seen.done    = out_tlast;
      seen.dropped = out_tuser[0];
      if (match_counts_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result item with nothing expected", $realtime);
        mismatches++;
      end else begin
        want = match_counts_due.pop_front();
        if (seen.m_el !== want.m_el || seen.m_tok !== want.m_tok ||
            seen.done !== want.done || seen.st_el !== want.st_el ||
            seen.st_tok !== want.st_tok || seen.dropped !== want.dropped) begin
          if (mismatches < 10) begin
            $display("%0t: exp matched %0d/%0d done %0b stored %0d/%0d drop %0b", $realtime,
                     want.m_el, want.m_tok, want.done, want.st_el, want.st_tok, want.dropped);
            $display("%0t: got matched %0d/%0d done %0b stored %0d/%0d drop %0b", $realtime,
                     seen.m_el, seen.m_tok, seen.done, seen.st_el, seen.st_tok, seen.dropped);
          end
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned tok_add(int unsigned a, int unsigned b);
    return (a + b > TOK_MAX) ? TOK_MAX : a + b;
  endfunction

  function automatic void prefix_cache_apply(logic [1:0] op, bit media, logic [63:0] value,
                                             logic [ELEN_W-1:0] mlen, bit q_first, bit q_last,
                                             logic [CNT_W-1:0] keep);
    int unsigned   len;
    bit            hit;
    cache_counts_t r;
    len = !media ? 1 : ((mlen > MAX_MEDIA_TOKENS) ? MAX_MEDIA_TOKENS : 32'(mlen));
    r = '0;
    case (op)
      OP_APPEND: begin
        if (n_stored < DEPTH) begin
          sh_kind[n_stored]   = media;
          sh_value[n_stored]  = value;
          sh_len[n_stored]    = ELEN_W'(len);
          tok_total           = tok_add(tok_total, len);
          sh_prefix[n_stored] = TOK_W'(tok_total);
          n_stored++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      OP_MATCH: begin
        if (q_first) begin
          q_idx   = 0;
          q_alive = 1'b1;
          q_elems = 0;
          q_toks  = 0;
        end
        if (q_alive) begin
          hit = 1'b0;
          if (q_idx < n_stored)
            hit = sh_kind[q_idx] == media && sh_value[q_idx] == value &&
                  (!media || sh_len[q_idx] == len);
          if (hit) begin
            q_elems++;
            q_toks = tok_add(q_toks, 32'(sh_len[q_idx]));
          end else begin
            q_alive = 1'b0;
          end
        end
        if (q_idx < DEPTH)
          q_idx++;
        r.m_el  = CNT_W'(q_elems);
        r.m_tok = TOK_W'(q_toks);
        r.done  = q_last;
      end
      OP_TRUNCATE: begin
        if (keep < n_stored) begin
          tok_total = (keep == 0) ? 0 : 32'(sh_prefix[keep-1]);
          n_stored  = 32'(keep);
        end
      end
      OP_CLEAR: begin
        n_stored  = 0;
        tok_total = 0;
      end
      default: ;
    endcase
    r.st_el  = CNT_W'(n_stored);
    r.st_tok = TOK_W'(tok_total);
    match_counts_due = {match_counts_due, r};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ELEN_W-1:0] rand_mlen();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ELEN_W'($urandom_range(MAX_MEDIA_TOKENS + 1, 8191));
      2: return ELEN_W'(MAX_MEDIA_TOKENS);
      3: return ELEN_W'($urandom_range(1, MAX_MEDIA_TOKENS));
      default: return ELEN_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input bit media, input logic [63:0] value,
                           input logic [ELEN_W-1:0] mlen, input bit q_first, input bit q_last,
                           input logic [CNT_W-1:0] keep);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {keep, mlen, value};
    in_tuser  <= {q_first, media, op};
    in_tlast  <= q_last;
    do @(posedge clk); while (!in_tready);
    prefix_cache_apply(op, media, value, mlen, q_first, q_last, keep);
    items_sent++;
  endtask

  task automatic put_element(input bit media, input logic [63:0] value,
                             input logic [ELEN_W-1:0] mlen);
    send_item(OP_APPEND, media, value, mlen, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 2047)));
  endtask

  task automatic put_random_element();
    put_element($urandom_range(0, 3) == 0, rand_value(), rand_mlen());
  endtask

  task automatic query_element(input bit media, input logic [63:0] value,
                               input logic [ELEN_W-1:0] mlen, input bit qf, input bit ql);
    send_item(OP_MATCH, media, value, mlen, qf, ql, CNT_W'($urandom_range(0, 2047)));
  endtask

  task automatic cut_to(input int unsigned keep);
    send_item(OP_TRUNCATE, 1'($urandom_range(0, 1)), rand_value(),
              ELEN_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), CNT_W'(keep));
  endtask

  task automatic wipe();
    send_item(OP_CLEAR, 1'($urandom_range(0, 1)), rand_value(),
              ELEN_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 2047)));
  endtask

  // length of a plain token is don't-care; a full-length media entry also
  // matches an oversize query length
  task automatic query_stored(input int unsigned pos, input bit qf, input bit ql);
    logic [ELEN_W-1:0] l;
    l = sh_len[pos];
    if (!sh_kind[pos])
      l = ELEN_W'($urandom_range(0, 8191));
    else if (l == MAX_MEDIA_TOKENS && $urandom_range(0, 1))
      l = ELEN_W'($urandom_range(MAX_MEDIA_TOKENS + 1, 8191));
    query_element(sh_kind[pos], sh_value[pos], l, qf, ql);
  endtask

  task automatic query_near_miss(input int unsigned pos, input bit qf, input bit ql);
    bit                k;
    logic [63:0]       v;
    logic [ELEN_W-1:0] l;
    int unsigned       b;
    k = sh_kind[pos];
    v = sh_value[pos];
    l = sh_len[pos];
    b = $urandom_range(0, 63);
    case ($urandom_range(0, 2))
      0: v[b] = ~v[b];
      1: k = !k;
      default: begin
        if (k)
          l = (l == 0) ? 13'd1 : l - 13'd1;
        else
          v = ~v;
      end
    endcase
    if (k == sh_kind[pos] && v == sh_value[pos] && (!k || l == sh_len[pos]))
      v = ~v;
    query_element(k, v, l, qf, ql);
  endtask

  task automatic run_query(input int unsigned len, input bit with_first, input bit with_last,
                           input bit whole);
    int unsigned diverge;
    int unsigned pos;
    bit          qf;
    bit          ql;
    diverge = (whole || $urandom_range(0, 2) == 0) ? len : $urandom_range(0, len);
    for (int unsigned i = 0; i < len; i++) begin
      qf = with_first && i == 0;
      ql = with_last && i == len - 1;
      if (!whole && i > 0 && $urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1))
          put_random_element();
        else
          cut_to($urandom_range(0, n_stored));
      end
      pos = qf ? 0 : q_idx;
      if (pos < n_stored && i < diverge)
        query_stored(pos, qf, ql);
      else if (pos < n_stored && $urandom_range(0, 1))
        query_near_miss(pos, qf, ql);
      else
        query_element($urandom_range(0, 3) == 0, rand_value(), rand_mlen(), qf, ql);
    end
  endtask

  task automatic test_directed();
    query_element(1'b0, '0, 13'd1, 1'b1, 1'b1);
    cut_to(0);
    put_element(1'b0, '0, 13'd7);
    put_element(1'b0, '1, 13'd0);
    put_element(1'b1, 64'hA5A5_5A5A_F00F_0FF0, 13'd0);
    put_element(1'b1, 64'h1234, 13'd4096);
    put_element(1'b1, 64'hBEEF, 13'd8191);
    put_element(1'b1, 64'h77, 13'd1);
    query_element(1'b0, '0, 13'h1FFF, 1'b1, 1'b0);
    query_element(1'b0, '1, 13'd0, 1'b0, 1'b0);
    query_element(1'b1, 64'hA5A5_5A5A_F00F_0FF0, 13'd0, 1'b0, 1'b0);
    query_element(1'b1, 64'h1234, 13'd4096, 1'b0, 1'b0);
    query_element(1'b1, 64'hBEEF, 13'd4097, 1'b0, 1'b1);
    query_element(1'b1, 64'h77, 13'd1, 1'b0, 1'b0);
    query_element(1'b0, '0, 13'd1, 1'b1, 1'b0);
    query_element(1'b1, '1, 13'd1, 1'b0, 1'b0);
    query_element(1'b0, '1, 13'd1, 1'b0, 1'b1);
    query_element(1'b1, '0, 13'd1, 1'b1, 1'b1);
    query_element(1'b0, '0, 13'd1, 1'b1, 1'b0);
    cut_to(1);
    query_element(1'b0, '1, 13'd1, 1'b0, 1'b1);
    cut_to(2047);
    cut_to(1);
    put_element(1'b1, 64'h10, 13'd5);
    query_element(1'b0, '0, 13'd1, 1'b1, 1'b0);
    query_element(1'b1, 64'h11, 13'd5, 1'b0, 1'b1);
    wipe();
  endtask

  // fill past capacity, then check the upper entries through truncation and the first entries through short matches
  task automatic test_fill_store();
    wipe();
    repeat (DEPTH + 2) put_random_element();
    run_query(8, 1'b1, 1'b1, 1'b1);
    cut_to(DEPTH - 1);
    cut_to($urandom_range(1, DEPTH - 2));
    run_query(8, 1'b1, 1'b1, 1'b0);
    wipe();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned sel;
    goal = TOTAL_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 39) == 0)
        calm = !calm;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        run_query($urandom_range(1, (n_stored + 3 > 30) ? 30 : n_stored + 3),
                  $urandom_range(0, 11) != 0, $urandom_range(0, 9) != 0, 1'b0);
      end else if (sel < 70) begin
        if (n_stored > 96)
          cut_to($urandom_range(0, 48));
        else
          repeat ($urandom_range(1, 8)) put_random_element();
      end else if (sel < 82) begin
        cut_to($urandom_range(0, 1) ? $urandom_range(0, n_stored) : $urandom_range(0, 2047));
      end else if (sel < 85) begin
        wipe();
      end else begin
        send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_value(),
                  ELEN_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 2047)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_store();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (match_counts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
